// ----- rtl/rowpe_pkg.sv -----
// rowpe_pkg: shared constants and types of the rgba-over-white planar encoder
// used by rowpe_lane, rowpe_emit and rgba_over_white_planar_encoder_top
`default_nettype none

package rowpe_pkg;

    localparam int unsigned MAX_WIDTH = 65535;

    localparam int unsigned CH_W   = 8;
    localparam int unsigned COL_W  = 16;
    localparam int unsigned PAD_W  = COL_W + 1;
    localparam int unsigned OFF_W  = 18;
    localparam int unsigned LANES  = 3;

    // c*a + 255*(255-a) + 127 == FULL_SCALE - a*(255-c)
    localparam logic [CH_W-1:0] CH_MAX     = 8'd255;
    localparam logic [15:0]     FULL_SCALE = 16'd65152;

    // configuration register indexes
    localparam logic [0:0] CFG_ROW_WIDTH = 1'b0;
    localparam logic [0:0] CFG_GRAY_MODE = 1'b1;

    // one pixel after the compositing lanes, ready for the emitter
    typedef struct packed {
        logic [LANES-1:0][CH_W-1:0] ch;
        logic [COL_W-1:0]           col;
        logic [COL_W-1:0]           width;
        logic [PAD_W-1:0]           padded;
        logic                       last;
        logic                       pad;
        logic                       gray_mode;
    } pix_rec_t;

endpackage

`default_nettype wire

// ----- rtl/rowpe_lane.sv -----
// rowpe_lane: one color channel composited over white, registered result
// depends on rowpe_pkg
`default_nettype none

module rowpe_lane (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [rowpe_pkg::CH_W-1:0] chan,
    input  wire logic [rowpe_pkg::CH_W-1:0] alpha,
    output logic      [rowpe_pkg::CH_W-1:0] comp
);

    logic [15:0]                  prod;
    logic [15:0]                  num;
    logic [16:0]                  sum;
    logic [rowpe_pkg::CH_W-1:0]   comp_reg;
    logic [rowpe_pkg::CH_W-1:0]   comp_next;

    assign prod = {8'd0, alpha} * {8'd0, rowpe_pkg::CH_MAX - chan};
    assign num  = rowpe_pkg::FULL_SCALE - prod;
    // exact x/255 for x up to FULL_SCALE
    assign sum  = {1'b0, num} + 17'd1 + {9'd0, num[15:8]};
    assign comp_next = sum[15:8];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            comp_reg <= comp_next;
        end
    end

    assign comp = comp_reg;

endmodule

`default_nettype wire

// ----- rtl/rowpe_emit.sv -----
// rowpe_emit: merges the lane results into the gray flag and sends the
// plane bytes and pad bytes of one pixel, one word per cycle while m_tready is high; uses rowpe_pkg
`default_nettype none

module rowpe_emit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                rec_valid,
    input  wire rowpe_pkg::pix_rec_t rec,
    output logic                     rec_take,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [31:0]              m_tdata,  // plane_byte[7:0], byte_offset[25:8], zeros
    output logic                     m_tlast,  // row_done
    output logic                     m_tuser   // row_gray
);

    rowpe_pkg::pix_rec_t          rec_reg;
    logic                         valid_reg;
    logic                         gray_reg;
    logic                         gs_reg;
    logic [1:0]                   plane_reg;
    logic                         pad_phase_reg;

    logic                         gray_in;
    logic [1:0]                   plane_last;
    logic                         end_item;
    logic                         fire;
    logic [rowpe_pkg::CH_W-1:0]   byte_val;
    logic [rowpe_pkg::OFF_W-1:0]  base;
    logic [rowpe_pkg::OFF_W-1:0]  plane_off;
    logic [rowpe_pkg::OFF_W-1:0]  offset;

    assign gray_in = gs_reg && (rec.ch[1] == rec.ch[0]) && (rec.ch[2] == rec.ch[0]);

    assign plane_last = rec_reg.gray_mode ? 2'd0 : 2'd2;
    assign end_item   = (plane_reg == plane_last) && (pad_phase_reg || !rec_reg.pad);
    assign fire       = valid_reg && m_tready;
    assign rec_take   = rec_valid && (!valid_reg || (fire && end_item));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            gs_reg        <= 1'b1;
            plane_reg     <= 2'd0;
            pad_phase_reg <= 1'b0;
        end
        else if (rec_take)
        begin
            valid_reg     <= 1'b1;
            gs_reg        <= rec.last ? 1'b1 : gray_in;
            plane_reg     <= 2'd0;
            pad_phase_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (end_item)
            begin
                valid_reg <= 1'b0;
            end
            else if (plane_reg == plane_last)
            begin
                // channel bytes done, pad bytes follow
                plane_reg     <= 2'd0;
                pad_phase_reg <= 1'b1;
            end
            else
            begin
                plane_reg <= plane_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_take)
        begin
            rec_reg  <= rec;
            gray_reg <= gray_in;
        end
    end

    always_comb
    begin
        unique case (plane_reg)
            2'd0:
            begin
                byte_val  = rec_reg.ch[0];
                plane_off = '0;
            end
            2'd1:
            begin
                byte_val  = rec_reg.ch[1];
                plane_off = {1'b0, rec_reg.padded};
            end
            2'd2:
            begin
                byte_val  = rec_reg.ch[2];
                plane_off = {rec_reg.padded, 1'b0};
            end
            default:
            begin
                byte_val  = '0;
                plane_off = '0;
            end
        endcase
        if (pad_phase_reg)
        begin
            byte_val = '0;
            base     = {2'b00, rec_reg.width};
        end
        else
        begin
            base = {2'b00, rec_reg.col};
        end
        offset = base + plane_off;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, offset, byte_val};
    assign m_tlast  = rec_reg.last && end_item;
    assign m_tuser  = gray_reg;

endmodule

`default_nettype wire

// ----- rtl/rgba_over_white_planar_encoder_top.sv -----
// rgba_over_white_planar_encoder_top: pixel intake, row position tracking,
// three compositing lanes and the byte emitter; uses rowpe_pkg, rowpe_lane, rowpe_emit
`default_nettype none

// Takes one RGBA pixel per word and sends the pixel composited over white as
// planar bytes, each with its offset in a row padded to even width. A pixel
// is sent as three plane bytes in color mode and one in gray mode, plus as many
// pad bytes on the last pixel of an odd-width row; the single output channel
// carries one byte per cycle while m_tready is high. The three channels are
// composited in parallel lanes into registers as the pixel is taken, and the
// emitter loads the result into its own register once it is free. A new pixel
// is taken while the previous one is still being sent.
// row_width and gray_mode may only be written while idle.
module rgba_over_white_planar_encoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // plane_byte[7:0], byte_offset[25:8], zeros
    output logic             m_tlast,   // row_done
    output logic             m_tuser    // row_gray
);

    localparam logic [rowpe_pkg::PAD_W-1:0] MAX_W = rowpe_pkg::PAD_W'(rowpe_pkg::MAX_WIDTH);

    logic [rowpe_pkg::COL_W-1:0] width_reg;
    logic                        gray_mode_reg;
    logic [rowpe_pkg::COL_W-1:0] col_reg;
    logic [rowpe_pkg::COL_W-1:0] col_next;
    logic                        s1_valid_reg;
    logic                        s1_valid_next;

    logic [rowpe_pkg::COL_W-1:0] col_s1_reg;
    logic [rowpe_pkg::COL_W-1:0] width_s1_reg;
    logic [rowpe_pkg::PAD_W-1:0] padded_s1_reg;
    logic                        last_s1_reg;
    logic                        pad_s1_reg;
    logic                        gmode_s1_reg;

    logic [rowpe_pkg::COL_W-1:0] w_eff;
    logic [rowpe_pkg::PAD_W-1:0] padded;
    logic                        last;
    logic                        accept;
    logic                        rec_take;
    logic [rowpe_pkg::LANES-1:0][rowpe_pkg::CH_W-1:0] ch;
    rowpe_pkg::pix_rec_t         rec;

    // zero width counts as one, clamp to the supported maximum
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = rowpe_pkg::COL_W'(1);
        end
        else if ({1'b0, width_reg} > MAX_W)
        begin
            w_eff = MAX_W[rowpe_pkg::COL_W-1:0];
        end
        else
        begin
            w_eff = width_reg;
        end
    end

    assign padded   = ({1'b0, w_eff} + rowpe_pkg::PAD_W'(1)) & ~rowpe_pkg::PAD_W'(1);
    assign last     = col_reg >= (w_eff - rowpe_pkg::COL_W'(1));
    assign s_tready = !s1_valid_reg || rec_take;
    assign accept   = s_tvalid && s_tready;
    assign col_next = last ? '0 : col_reg + rowpe_pkg::COL_W'(1);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (rec_take)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= rowpe_pkg::COL_W'(1);
            gray_mode_reg <= 1'b0;
            col_reg       <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rowpe_pkg::CFG_ROW_WIDTH: width_reg     <= cfg_data;
                    rowpe_pkg::CFG_GRAY_MODE: gray_mode_reg <= cfg_data[0];
                    default:                  width_reg     <= width_reg;
                endcase
            end
            if (accept)
            begin
                col_reg <= col_next;
            end
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_s1_reg    <= col_reg;
            width_s1_reg  <= w_eff;
            padded_s1_reg <= padded;
            last_s1_reg   <= last;
            pad_s1_reg    <= last && w_eff[0];
            gmode_s1_reg  <= gray_mode_reg;
        end
    end

    for (genvar i = 0; i < rowpe_pkg::LANES; i++)
    begin : g_lane
        rowpe_lane u_lane (
            .clk   (clk),
            .en    (accept),
            .chan  (s_tdata[i*rowpe_pkg::CH_W +: rowpe_pkg::CH_W]),
            .alpha (s_tdata[rowpe_pkg::LANES*rowpe_pkg::CH_W +: rowpe_pkg::CH_W]),
            .comp  (ch[i])
        );
    end

    always_comb
    begin
        rec.ch        = ch;
        rec.col       = col_s1_reg;
        rec.width     = width_s1_reg;
        rec.padded    = padded_s1_reg;
        rec.last      = last_s1_reg;
        rec.pad       = pad_s1_reg;
        rec.gray_mode = gmode_s1_reg;
    end

    rowpe_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (s1_valid_reg),
        .rec       (rec),
        .rec_take  (rec_take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ----- tb/rgba_over_white_planar_encoder_top_tb.sv -----
// rgba_over_white_planar_encoder_top_tb: self-checking bench for the rgba-over-white planar encoder
// predicts every planar byte per accepted pixel and checks the output stream word by word
// depends on rowpe_pkg and rgba_over_white_planar_encoder_top
module rgba_over_white_planar_encoder_top_tb;

    typedef struct {
        logic [7:0]  pbyte;
        logic [17:0] offset;
        logic        done;
        logic        gray;
    } plane_word_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    logic [31:0] pixel_q[$];
    plane_word_t owed_bytes[$];
    int          mismatches = 0;
    int          send_idle  = 29;
    int          recv_idle  = 48;
    bit          m_hold     = 1'b0;
    bit          hold_req   = 1'b0;

    // shadow of the encoder registers and row state
    logic [15:0] cur_width     = 16'd1;
    logic        cur_gray_mode = 1'b0;
    logic [15:0] col_pos       = '0;
    logic        row_is_gray   = 1'b1;

    rgba_over_white_planar_encoder_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] blend_white(logic [7:0] c, logic [7:0] a);
        int unsigned cv, av, v;
        cv = c;
        av = a;
        v  = (cv * av + 255 * (255 - av) + 127) / 255;
        return v[7:0];
    endfunction

    function automatic void encode_pixel(logic [31:0] pixel);
        int unsigned w, padded, planes, total, n, p;
        logic [7:0]  shade [3];
        logic        gray_now, last, pad;
        plane_word_t item;
        w = cur_width;
        if (w == 0)
            w = 1;
        if (w > rowpe_pkg::MAX_WIDTH)
            w = rowpe_pkg::MAX_WIDTH;
        padded = (w + 1) & ~32'd1;
        planes = cur_gray_mode ? 1 : 3;
        for (p = 0; p < 3; p++)
            shade[p] = blend_white(pixel[8*p +: 8], pixel[31:24]);
        // gray flag always looks at all three channels
        gray_now = row_is_gray && shade[1] == shade[0] && shade[2] == shade[0];
        last     = (col_pos >= w - 1);
        pad      = last && w[0];
        total    = pad ? 2 * planes : planes;
        n        = 0;
        for (p = 0; p < planes; p++)
        begin
            n++;
            item.pbyte  = shade[p];
            item.offset = 18'(p * padded + col_pos);
            item.done   = last && n == total;
            item.gray   = gray_now;
            owed_bytes.push_back(item);
        end
        if (pad)
        begin
            for (p = 0; p < planes; p++)
            begin
                n++;
                item.pbyte  = 8'd0;
                item.offset = 18'(p * padded + w);
                item.done   = (n == total);
                item.gray   = gray_now;
                owed_bytes.push_back(item);
            end
        end
        if (last)
        begin
            col_pos     = '0;
            row_is_gray = 1'b1;
        end
        else
        begin
            col_pos     = col_pos + 16'd1;
            row_is_gray = gray_now;
        end
    endfunction

    function automatic logic [31:0] rand_pixel(bit gray_only);
        logic [7:0] r, g, b, a;
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        a = 8'($urandom);
        case ($urandom_range(7))
            0, 1:
            begin
                g = r;
                b = r;
            end
            2: a = $urandom_range(1) ? 8'hFF : 8'h00;
            // near-gray: low alpha rounds the difference away
            3:
            begin
                g = r ^ 8'd1;
                b = r;
                a = 8'($urandom_range(0, 3));
            end
            default: ;
        endcase
        if (gray_only)
        begin
            g = r;
            b = r;
        end
        return {a, b, g, r};
    endfunction

    task automatic px(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        pixel_q.push_back({a, b, g, r});
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pixel_q.size() != 0 || s_tvalid || owed_bytes.size() != 0);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == rowpe_pkg::CFG_ROW_WIDTH)
            cur_width = val;
        else
            cur_gray_mode = val[0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // pixel driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                encode_pixel(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixel_q.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // byte monitor
    always @(posedge clk)
    begin : mon
        plane_word_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (owed_bytes.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, got tdata=%h", $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = owed_bytes.pop_front();
                    if (m_tdata[7:0] !== want.pbyte)
                    begin
                        $display("%0t: plane_byte expected %h got %h", $time, want.pbyte,
                                 m_tdata[7:0]);
                        mismatches++;
                    end
                    if (m_tdata[25:8] !== want.offset)
                    begin
                        $display("%0t: byte_offset expected %0d got %0d", $time, want.offset,
                                 m_tdata[25:8]);
                        mismatches++;
                    end
                    if (m_tdata[31:26] !== 6'd0)
                    begin
                        $display("%0t: tdata fill expected 0 got %h", $time, m_tdata[31:26]);
                        mismatches++;
                    end
                    if (m_tlast !== want.done)
                    begin
                        $display("%0t: row_done expected %b got %b", $time, want.done, m_tlast);
                        mismatches++;
                    end
                    if (m_tuser !== want.gray)
                    begin
                        $display("%0t: row_gray expected %b got %b", $time, want.gray, m_tuser);
                        mismatches++;
                    end
                end
            end
            m_tready <= !m_hold && ($urandom_range(99) >= recv_idle);
        end
    end

    // receiver hold-off, counted here while the sender keeps going
    initial
    begin
        wait (hold_req);
        m_hold = 1'b1;
        repeat (300) @(negedge clk);
        m_hold = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int          rand_count, count, eff, pick, i;
        logic [15:0] width;
        bit          held, paused, gray_only;
        rand_count = 0;
        held       = 1'b0;
        paused     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset config: width 1 in color, every pixel pads
        px(0, 0, 0, 0);
        px(255, 255, 255, 255);
        px(255, 0, 128, 255);
        px(0, 255, 0, 128);
        px(1, 2, 3, 127);
        px(254, 253, 252, 1);
        wait_drained();

        // zero width acts as one, gray plane only
        write_reg(rowpe_pkg::CFG_ROW_WIDTH, 16'd0);
        write_reg(rowpe_pkg::CFG_GRAY_MODE, 16'd1);
        px(200, 100, 50, 255);
        px(10, 10, 10, 200);
        px(255, 255, 255, 0);
        wait_drained();

        // shrink width mid-row: even new width, row ends with no pad
        write_reg(rowpe_pkg::CFG_ROW_WIDTH, 16'd4);
        write_reg(rowpe_pkg::CFG_GRAY_MODE, 16'd0);
        px(9, 9, 9, 255);
        px(128, 128, 128, 64);
        wait_drained();
        write_reg(rowpe_pkg::CFG_ROW_WIDTH, 16'd2);
        px(7, 7, 8, 255);
        wait_drained();

        // shrink to odd width mid-row: pads land at the new width
        write_reg(rowpe_pkg::CFG_ROW_WIDTH, 16'd5);
        px(50, 50, 50, 0);
        px(3, 4, 5, 255);
        px(0, 0, 0, 255);
        wait_drained();
        write_reg(rowpe_pkg::CFG_ROW_WIDTH, 16'd3);
        px(100, 100, 100, 100);
        wait_drained();

        write_reg(rowpe_pkg::CFG_ROW_WIDTH, 16'hFFFF);
        write_reg(rowpe_pkg::CFG_GRAY_MODE, 16'd1);
        px(1, 1, 1, 1);
        px(128, 64, 32, 16);
        wait_drained();
        write_reg(rowpe_pkg::CFG_ROW_WIDTH, 16'd1);
        px(0, 255, 255, 255);
        wait_drained();

        // full even row of gray pixels
        write_reg(rowpe_pkg::CFG_ROW_WIDTH, 16'd6);
        write_reg(rowpe_pkg::CFG_GRAY_MODE, 16'd0);
        for (i = 0; i < 6; i++)
            px(8'(i * 40), 8'(i * 40), 8'(i * 40), 8'(255 - i * 50));

        while (rand_count < 250)
        begin
            if (rand_count < 85)
            begin
                send_idle = 29;
                recv_idle = 48;
            end
            else if (rand_count < 170)
            begin
                send_idle = 48;
                recv_idle = 29;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            wait_drained();
            pick = $urandom_range(19);
            if (pick == 0)
                width = 16'd0;
            else if (pick == 1)
                width = 16'hFFFF;
            else if (pick < 5)
                width = 16'($urandom_range(10, 40));
            else
                width = 16'($urandom_range(1, 9));
            write_reg(rowpe_pkg::CFG_ROW_WIDTH, width);
            write_reg(rowpe_pkg::CFG_GRAY_MODE, 16'($urandom_range(1)));
            eff = (width == 0) ? 1 : width;
            if (width == 16'hFFFF)
                count = $urandom_range(1, 4);
            else if (eff > 9)
                count = eff + $urandom_range(0, 2);
            else
                count = eff * $urandom_range(1, 2) + $urandom_range(0, 2);
            gray_only = ($urandom_range(2) == 0);
            repeat (count) pixel_q.push_back(rand_pixel(gray_only));
            rand_count += count;
            if (!held && rand_count >= 30)
            begin
                // keep offering while the output is blocked
                repeat (20) pixel_q.push_back(rand_pixel(gray_only));
                rand_count += 20;
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if (!paused && rand_count >= 95)
            begin
                // sender stops until the encoder has sent everything
                wait_drained();
                repeat (count) pixel_q.push_back(rand_pixel(gray_only));
                rand_count += count;
                paused = 1'b1;
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
